// ===== rtl/mbe_pkg.sv =====
// Package for the Mandelbrot escape-time engine: payload types, register
// indexes, fixed-point constants and saturation helpers.
// No dependencies.
`default_nettype none

package mbe_pkg;

    // Field widths and fixed-point format
    localparam int PIXEL_BITS = 12;
    localparam int FRAC_BITS  = 28;
    localparam int COUNT_BITS = 16;
    localparam int VAL_BITS   = 32;               // Q4.28 value width
    localparam int WIDE_BITS  = 2 * VAL_BITS;     // full product width

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = VAL_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_RE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_IM = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_RE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_IM   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ITER  = 3'd4;

    // Reset values of the registers
    localparam logic signed [VAL_BITS-1:0] RST_ORIGIN_RE = -32'sd536870912;
    localparam logic signed [VAL_BITS-1:0] RST_ORIGIN_IM = -32'sd268435456;
    localparam logic signed [VAL_BITS-1:0] RST_STEP_RE   = 32'sd629146;
    localparam logic signed [VAL_BITS-1:0] RST_STEP_IM   = 32'sd745654;
    localparam logic [COUNT_BITS-1:0]      RST_MAX_ITER  = COUNT_BITS'(128);

    // Rounding offsets: real part drops FRAC_BITS, imaginary part (2*zr*zi)
    // drops FRAC_BITS-1
    localparam logic signed [WIDE_BITS-1:0] HALF_RE = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [WIDE_BITS-1:0] HALF_IM = 64'sd1 <<< (FRAC_BITS - 2);

    // Escape when |z|^2 >= 4.0, which carries 2*FRAC_BITS fraction bits
    localparam int                  ESC_SHIFT = 2 * FRAC_BITS + 2;
    localparam logic                ESC_EN    = (2 * FRAC_BITS < 62);
    localparam logic [WIDE_BITS-1:0] ESC_LIMIT = 64'd1 << ESC_SHIFT;

    localparam logic signed [WIDE_BITS-1:0] WIDE_MAX = (64'sd1 <<< (VAL_BITS - 1)) - 64'sd1;
    localparam logic signed [WIDE_BITS-1:0] WIDE_MIN = -(64'sd1 <<< (VAL_BITS - 1));

    // Payloads
    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_x;
        logic [PIXEL_BITS-1:0] pixel_y;
    } t_in;

    typedef struct packed {
        logic [COUNT_BITS-1:0] iteration_count;
        logic                  escaped;
    } t_out;

    // Clamp a wide signed value to the Q4.28 range
    function automatic logic signed [VAL_BITS-1:0] sat_val(
        input logic signed [WIDE_BITS-1:0] v
    );
        logic signed [VAL_BITS-1:0] res;
        if (v > WIDE_MAX) begin
            res = WIDE_MAX[VAL_BITS-1:0];
        end else if (v < WIDE_MIN) begin
            res = WIDE_MIN[VAL_BITS-1:0];
        end else begin
            res = v[VAL_BITS-1:0];
        end
        return res;
    endfunction

    // Sign-extend a value to product width
    function automatic logic signed [WIDE_BITS-1:0] sext_val(
        input logic signed [VAL_BITS-1:0] v
    );
        return {{(WIDE_BITS - VAL_BITS){v[VAL_BITS-1]}}, v};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mandelbrot_escape_time_top.sv =====
// Mandelbrot escape-time engine: maps a pixel to c and iterates z = z*z + c
// on one shared multiplier under a small sequencer.
// Depends on mbe_pkg and mbe_mul.
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------
//  pixel in  | start, busy            | i_pixel (t_in)
//  result    | o_done (1-cycle pulse) | o_result (t_out)
//  config    | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// A transaction forms c in S_CRE, S_CIM and S_CIX, then makes one pass of
// S_MRR, S_MII, S_MRI and S_UPD per iteration plus a last pass that tests
// and finishes; busy is high throughout, with the single multiplier doing
// zr*zr, zi*zi and zr*zi in turn. The result sits on o_result for the o_done
// cycle that follows; busy is low there and a new start is taken in that
// same cycle. The receiver cannot stall.
// Reset (synchronous, active low) restores the register defaults and idles
// the sequencer.
`default_nettype none

module mandelbrot_escape_time_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire mbe_pkg::t_in                         i_pixel,
    output logic                                      o_done,
    output mbe_pkg::t_out                             o_result,
    input  wire logic                                 i_cfg_we,
    input  wire logic [mbe_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  wire logic [mbe_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import mbe_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CRE  = 3'd1;  // multiply px * step_real
    localparam logic [2:0] S_CIM  = 3'd2;  // multiply py * step_imag, form cr
    localparam logic [2:0] S_CIX  = 3'd3;  // form ci
    localparam logic [2:0] S_MRR  = 3'd4;  // multiply zr * zr
    localparam logic [2:0] S_MII  = 3'd5;  // multiply zi * zi
    localparam logic [2:0] S_MRI  = 3'd6;  // multiply zr * zi, escape test
    localparam logic [2:0] S_UPD  = 3'd7;  // update z or finish

    // Configuration registers
    logic signed [VAL_BITS-1:0] r_origin_re, r_origin_im, r_step_re, r_step_im;
    logic [COUNT_BITS-1:0]      r_max;

    // Datapath and control registers
    logic [2:0]                  r_state, n_state;
    logic [PIXEL_BITS-1:0]       r_py;
    logic [PIXEL_BITS-1:0]       r_px;
    logic signed [VAL_BITS-1:0]  r_cr, r_ci, r_zr, r_zi;
    logic signed [WIDE_BITS-1:0] r_rr, r_dif;
    logic                        r_out;
    logic [COUNT_BITS-1:0]       r_cnt;
    logic                        r_done;
    t_out                        r_result;

    logic signed [VAL_BITS-1:0]  mul_a, mul_b;
    logic signed [WIDE_BITS-1:0] prod;
    logic                        accept;
    logic                        at_limit;
    logic                        finish;
    logic [WIDE_BITS-1:0]        mag;
    logic signed [WIDE_BITS-1:0] re_sum, im_sum;

    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign at_limit = (r_cnt >= r_max);
    assign finish   = r_out || at_limit;

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_re <= RST_ORIGIN_RE;
            r_origin_im <= RST_ORIGIN_IM;
            r_step_re   <= RST_STEP_RE;
            r_step_im   <= RST_STEP_IM;
            r_max       <= RST_MAX_ITER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ORIGIN_RE: r_origin_re <= i_cfg_data;
                REG_ORIGIN_IM: r_origin_im <= i_cfg_data;
                REG_STEP_RE:   r_step_re   <= i_cfg_data;
                REG_STEP_IM:   r_step_im   <= i_cfg_data;
                REG_MAX_ITER:  r_max       <= i_cfg_data[COUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            S_CRE: begin
                mul_a = {{(VAL_BITS - PIXEL_BITS){1'b0}}, r_px};
                mul_b = r_step_re;
            end
            S_CIM: begin
                mul_a = {{(VAL_BITS - PIXEL_BITS){1'b0}}, r_py};
                mul_b = r_step_im;
            end
            S_MRR: begin
                mul_a = r_zr;
                mul_b = r_zr;
            end
            S_MII: begin
                mul_a = r_zi;
                mul_b = r_zi;
            end
            default: begin
                mul_a = r_zr;
                mul_b = r_zi;
            end
        endcase
    end

    mbe_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // |z|^2 from zr*zr (r_rr) and zi*zi (product register during S_MRI)
    assign mag = WIDE_BITS'(r_rr) + WIDE_BITS'(prod);

    // Rounded new components plus c; prod holds zr*zi during S_UPD
    assign re_sum = ((r_dif + HALF_RE) >>> FRAC_BITS) + sext_val(r_cr);
    assign im_sum = ((prod + HALF_IM) >>> (FRAC_BITS - 1)) + sext_val(r_ci);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) n_state = S_CRE;
            S_CRE:  n_state = S_CIM;
            S_CIM:  n_state = S_CIX;
            S_CIX:  n_state = S_MRR;
            S_MRR:  n_state = S_MII;
            S_MII:  n_state = S_MRI;
            S_MRI:  n_state = S_UPD;
            S_UPD:  n_state = finish ? S_IDLE : S_MRR;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_UPD) && finish;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px  <= i_pixel.pixel_x;
            r_py  <= i_pixel.pixel_y;
            r_zr  <= '0;
            r_zi  <= '0;
            r_cnt <= '0;
        end
        unique case (r_state)
            S_CIM: r_cr <= sat_val(sext_val(r_origin_re) + prod);
            S_CIX: r_ci <= sat_val(sext_val(r_origin_im) + prod);
            S_MII: r_rr <= prod;
            S_MRI: begin
                r_dif <= r_rr - prod;
                r_out <= ESC_EN && (mag >= ESC_LIMIT);
            end
            S_UPD: begin
                if (finish) begin
                    r_result.iteration_count <= r_cnt;
                    r_result.escaped         <= !at_limit;
                end else begin
                    r_zr  <= sat_val(re_sum);
                    r_zi  <= sat_val(im_sum);
                    r_cnt <= r_cnt + COUNT_BITS'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // A result only follows the finishing update step
    a_done_after_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == S_UPD)
        else $error("result strobe without a finishing update");

    // An escaped point never reports a count at the limit
    a_escaped_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.escaped) |-> (o_result.iteration_count < r_max))
        else $error("escaped result with count at or above the limit");

    // A point that did not escape stopped exactly at the limit
    a_inside_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.escaped) |-> (o_result.iteration_count == r_max))
        else $error("non-escaped result with count off the limit");

    // An accepted transaction starts forming c next cycle
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_CRE))
        else $error("accepted transaction did not start the sequencer");

endmodule

`default_nettype wire

// ===== rtl/mbe_mul.sv =====
// Shared 32x32 signed multiplier with a registered 64-bit product.
// Depends on mbe_pkg.
`default_nettype none

module mbe_mul (
    input  wire logic                                  i_clk,
    input  wire logic signed [mbe_pkg::VAL_BITS-1:0]   i_a,
    input  wire logic signed [mbe_pkg::VAL_BITS-1:0]   i_b,
    output logic signed [mbe_pkg::WIDE_BITS-1:0]       o_prod
);
    import mbe_pkg::*;

    logic signed [WIDE_BITS-1:0] r_prod;

    // One full-width product per cycle, registered
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire
